// ===== design/lbph_pkg.sv =====
// lbph_pkg: shared sizes, codes and types for the LBP code and histogram block.
// No dependencies; compiled first.
package lbph_pkg;

  // Frame limits
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned MIN_SIZE   = 3;

  // Field widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned BIN_W     = 8;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned COUNT_W   = 20;
  localparam int unsigned BINS      = 256;
  localparam int unsigned WIN_N     = 6;

  // Configuration port
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_RST   = 1024;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  // Word codes
  localparam logic CMD_PIXEL  = 1'b0;
  localparam logic CMD_READ   = 1'b1;
  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CODE,
    OP_READ,
    OP_CLEAR
  } lbph_op_t;

  typedef struct packed {
    lbph_op_t            op;
    logic [CODE_W-1:0]   index;  // code to count, or bin to read
    logic                eof;
  } lbph_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lbph_q_stat_t;

  typedef struct packed {
    logic                 write;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } lbph_cfg_wr_t;

  // Size register value clamped to [MIN_SIZE, vmax]
  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                             input int unsigned vmax);
    int unsigned r;
    r = int'(v);
    if (r < MIN_SIZE) r = MIN_SIZE;
    if (r > vmax) r = vmax;
    return r;
  endfunction

  localparam logic [COL_W-1:0] COL_LAST_RST =
    COL_W'(clamp_size(CFG_W'(CFG_RST), MAX_WIDTH) - 1);
  localparam logic [ROW_W-1:0] ROW_LAST_RST =
    ROW_W'(clamp_size(CFG_W'(CFG_RST), MAX_HEIGHT) - 1);

endpackage

// ===== design/lbph_if.sv =====
// lbph_if: valid/ready channels for pixel/read words and result words.
// Depends on lbph_pkg for field widths.
interface lbph_pix_if import lbph_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PIX_W-1:0] pixel;
  logic [BIN_W-1:0] bin_index;

  modport source (output valid, cmd, pixel, bin_index, input ready);
  modport sink   (input valid, cmd, pixel, bin_index, output ready);
endinterface

interface lbph_res_if import lbph_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [CODE_W-1:0]  lbp_code;
  logic [COUNT_W-1:0] bin_count;
  logic               end_of_frame;

  modport source (output valid, kind, lbp_code, bin_count, end_of_frame, input ready);
  modport sink   (input valid, kind, lbp_code, bin_count, end_of_frame, output ready);
endinterface

// ===== design/lbph_front.sv =====
// lbph_front: word intake, raster position, line stores, 3x3 window and code.
// Depends on lbph_pkg and lbph_pix_if; feeds lbph_queue.
module lbph_front import lbph_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  lbph_pix_if.sink     pixels,
  input  lbph_cfg_wr_t cfg,
  input  lbph_q_stat_t q_stat,
  output logic         q_push,
  output lbph_entry_t  q_data
);

  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  logic [PIX_W-1:0] upper_line  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_line [MAX_WIDTH];
  logic [PIX_W-1:0] rd_top;
  logic [PIX_W-1:0] rd_mid;
  logic [PIX_W-1:0] win [WIN_N];

  // stage 1 word
  logic             s1_valid;
  logic             s1_cmd;
  logic [PIX_W-1:0] s1_pix;
  logic [BIN_W-1:0] s1_bin;
  logic [COL_W-1:0] s1_col;
  logic             s1_interior;
  logic             s1_first;
  logic             s1_last;

  logic              acc;
  logic              acc_pix;
  logic              need_push;
  logic              s1_fire;
  logic              s1_pix_fire;
  logic [CODE_W-1:0] code;
  logic [PIX_W-1:0]  centre;

  assign acc     = pixels.valid && pixels.ready;
  assign acc_pix = acc && (pixels.cmd == CMD_PIXEL);

  assign need_push   = (s1_cmd == CMD_READ) || s1_first || s1_interior;
  assign s1_fire     = s1_valid && (!need_push || !q_stat.full);
  assign s1_pix_fire = s1_fire && (s1_cmd == CMD_PIXEL);
  assign q_push      = s1_valid && need_push && !q_stat.full;
  assign pixels.ready = !s1_valid || s1_fire;

  // neighbour >= centre, clockwise from top-left
  always_comb begin
    centre  = win[4];
    code[0] = win[0] >= centre;
    code[1] = win[3] >= centre;
    code[2] = rd_top >= centre;
    code[3] = rd_mid >= centre;
    code[4] = s1_pix >= centre;
    code[5] = win[5] >= centre;
    code[6] = win[2] >= centre;
    code[7] = win[1] >= centre;
  end

  always_comb begin
    q_data.eof = s1_last;
    if (s1_cmd == CMD_READ) begin
      q_data.op    = OP_READ;
      q_data.index = s1_bin;
    end else if (s1_first) begin
      q_data.op    = OP_CLEAR;
      q_data.index = code;
    end else begin
      q_data.op    = OP_CODE;
      q_data.index = code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      col      <= '0;
      row      <= '0;
      col_last <= COL_LAST_RST;
      row_last <= ROW_LAST_RST;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (cfg.write) begin
        col <= '0;
        row <= '0;
        case (cfg.index)
          REG_WIDTH:  col_last <= COL_W'(clamp_size(cfg.data, MAX_WIDTH) - 1);
          REG_HEIGHT: row_last <= ROW_W'(clamp_size(cfg.data, MAX_HEIGHT) - 1);
          default: ;
        endcase
      end else if (acc_pix) begin
        if (col == col_last) begin
          col <= '0;
          row <= (row == row_last) ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd      <= pixels.cmd;
      s1_pix      <= pixels.pixel;
      s1_bin      <= pixels.bin_index;
      s1_col      <= col;
      s1_interior <= (row >= ROW_W'(2)) && (col >= COL_W'(2));
      s1_first    <= (row == '0) && (col == '0);
      s1_last     <= (row == row_last) && (col == col_last);
    end
  end

  // line stores: read on intake, write back when the word leaves stage 1
  always_ff @(posedge clk) begin
    if (s1_pix_fire) upper_line[s1_col] <= rd_mid;
    if (acc_pix) rd_top <= upper_line[col];
  end

  always_ff @(posedge clk) begin
    if (s1_pix_fire) middle_line[s1_col] <= s1_pix;
    if (acc_pix) rd_mid <= middle_line[col];
  end

  always_ff @(posedge clk) begin
    if (s1_pix_fire) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= rd_top;
      win[4] <= rd_mid;
      win[5] <= s1_pix;
    end
  end

endmodule

// ===== design/lbph_queue.sv =====
// lbph_queue: short FIFO of histogram operations between front and back.
// Depends on lbph_pkg.
module lbph_queue import lbph_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  lbph_entry_t  wr_data,
  input  logic         pop,
  output lbph_entry_t  head,
  output lbph_q_stat_t stat
);

  lbph_entry_t      slots [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_CW-1:0]  count;

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == Q_CW'(Q_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_AW'(1);
      if (push && !pop) begin
        count <= count + Q_CW'(1);
      end else if (pop && !push) begin
        count <= count - Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

endmodule

// ===== design/lbph_back.sv =====
// lbph_back: histogram read-modify-write with forwarding, bin reads, result register.
// Depends on lbph_pkg and lbph_res_if; fed by lbph_queue.
module lbph_back import lbph_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  lbph_entry_t  head,
  input  lbph_q_stat_t q_stat,
  output logic         pop,
  lbph_res_if.source   results
);

  logic [COUNT_W-1:0] hist [BINS];
  logic [BINS-1:0]    hvalid;

  logic               b2_valid;
  lbph_entry_t        b2;
  logic [COUNT_W-1:0] rd_cnt;
  logic               rd_vld;

  // last write, and a clear that may not yet show in a captured valid bit
  logic               fw_valid;
  logic [CODE_W-1:0]  fw_idx;
  logic [COUNT_W-1:0] fw_val;
  logic               clr_last;

  logic               out_valid;
  logic               out_kind;
  logic [CODE_W-1:0]  out_code;
  logic [COUNT_W-1:0] out_count;
  logic               out_eof;

  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] inc;
  logic               needs_out;
  logic               b2_fire;
  logic               is_read;

  always_comb begin
    if (fw_valid && (fw_idx == b2.index)) begin
      base = fw_val;
    end else if (clr_last || !rd_vld) begin
      base = '0;
    end else begin
      base = rd_cnt;
    end
    inc = (&base) ? base : base + COUNT_W'(1);  // saturate
  end

  assign is_read   = (b2.op == OP_READ);
  assign needs_out = (b2.op != OP_CLEAR);
  assign b2_fire   = b2_valid && (!needs_out || !out_valid || results.ready);
  assign pop       = !q_stat.empty && (!b2_valid || b2_fire);

  assign results.valid        = out_valid;
  assign results.kind         = out_kind;
  assign results.lbp_code     = out_code;
  assign results.bin_count    = out_count;
  assign results.end_of_frame = out_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
      hvalid    <= '0;
      fw_valid  <= 1'b0;
      clr_last  <= 1'b1;
    end else begin
      if (pop) begin
        b2_valid <= 1'b1;
      end else if (b2_fire) begin
        b2_valid <= 1'b0;
      end
      if (b2_fire && needs_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (b2_fire) begin
        unique case (b2.op)
          OP_CLEAR: begin
            hvalid   <= '0;
            fw_valid <= 1'b0;
            clr_last <= 1'b1;
          end
          OP_CODE: begin
            hvalid[b2.index] <= 1'b1;
            fw_valid         <= 1'b1;
            clr_last         <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b2     <= head;
      rd_cnt <= hist[head.index];
      rd_vld <= hvalid[head.index];
    end
    if (b2_fire && (b2.op == OP_CODE)) begin
      hist[b2.index] <= inc;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_fire && (b2.op == OP_CODE)) begin
      fw_idx <= b2.index;
      fw_val <= inc;
    end
    if (b2_fire && needs_out) begin
      out_kind  <= is_read ? KIND_COUNT : KIND_CODE;
      out_code  <= is_read ? '0 : b2.index;
      out_count <= is_read ? base : '0;
      out_eof   <= is_read ? 1'b0 : b2.eof;
    end
  end

endmodule

// ===== design/lbp8_code_and_histogram.sv =====
// lbp8_code_and_histogram: top level of the 3x3 LBP code and histogram block.
// Depends on lbph_pkg, lbph_if, lbph_front, lbph_queue and lbph_back.
//
// Pixels arrive as words in raster order (cmd 0) and histogram bin reads as
// words with cmd 1. Every interior pixel (row and column both at least 2)
// yields a code word: bit 0 top-left, then clockwise to bit 7 left, a bit set
// where the neighbour is at least the centre; the last interior pixel of a
// frame flags end_of_frame. Each code bumps its bin in a 256-bin histogram,
// saturating at 2^20-1; the first pixel of a frame clears all bins, and a
// read word returns one bin's count, ordered after every earlier word.
// Throughput is one word per clock on both channels unless results stall and
// the queue fills; words pass stage 1, the queue, b2 and the result register.
// The rate is set by the histogram read-modify-write, with the last write
// forwarded, and by the single read and write port of each line store.
// A four-entry queue lets the pixel side keep running while results stall.
// Bins are cleared by per-bin valid flops, so there is no clearing sweep
// after reset. Line stores are not initialised; no uninitialised entry
// ever reaches a result. Write image_width and image_height only while the
// block is idle; a write restarts the raster position at row 0, column 0.
module lbp8_code_and_histogram import lbph_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  lbph_pix_if.sink             pixels,
  lbph_res_if.source           results,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  lbph_cfg_wr_t cfg;
  lbph_q_stat_t q_stat;
  lbph_entry_t  q_wr;
  lbph_entry_t  q_head;
  logic         q_push;
  logic         q_pop;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // front: position, line stores, window, code
  lbph_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels),
    .cfg    (cfg),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_wr)
  );

  // decoupling queue of histogram operations
  lbph_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .head    (q_head),
    .stat    (q_stat)
  );

  // back: histogram update, bin reads, result word
  lbph_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_stat  (q_stat),
    .pop     (q_pop),
    .results (results)
  );

endmodule

// ===== design/lbph_checker.sv =====
// lbph_checker: port-level assertions for lbp8_code_and_histogram, with its bind.
// Depends on lbph_pkg; attaches to the top level.
module lbph_checker import lbph_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_kind,
  input logic [CODE_W-1:0]  out_code,
  input logic [COUNT_W-1:0] out_count,
  input logic               out_eof
);

  // reset empties the result register
  a_reset_clears : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // nothing can come out of an empty pipeline just out of reset
  a_no_spurious : assert property (@(posedge clk)
    (rst ##1 !(in_valid && in_ready)) |=> !out_valid)
    else $error("result word without any accepted word");

  // stalled result word holds
  a_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind)
      && $stable(out_code) && $stable(out_count) && $stable(out_eof)))
    else $error("stalled result word changed");

  // unused fields are zero for each kind
  a_fields : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_kind == KIND_COUNT) ? (out_code == '0 && !out_eof)
                                            : (out_count == '0)))
    else $error("result word carries stray field bits");

endmodule

bind lbp8_code_and_histogram lbph_checker u_lbph_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixels.valid),
  .in_ready  (pixels.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_kind  (results.kind),
  .out_code  (results.lbp_code),
  .out_count (results.bin_count),
  .out_eof   (results.end_of_frame)
);

// ===== tb/lbph_check.sv =====
`timescale 1ns / 100ps
// lbph_check: watches the word, result and register ports of the LBP block, runs its
// own copy of the raster, window and histogram state, and checks each result word.
// Depends on lbph_pkg and the lbph_if channel interfaces.
module lbph_check import lbph_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  lbph_pix_if                  pixels,
  lbph_res_if                  results,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   outstanding,
  output int                   codes_checked,
  output int                   counts_checked,
  output int                   frame_ends
);

  localparam int REPORT_LIMIT = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic               kind;
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] count;
    logic               eof;
  } res_word_t;

  res_word_t          awaited [$];
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic [PIX_W-1:0]   row_above2 [MAX_WIDTH];
  logic [PIX_W-1:0]   row_above1 [MAX_WIDTH];
  // [0..2] column two back (top, mid, bottom), [3..5] column one back
  logic [PIX_W-1:0]   cols_back [WIN_N];
  int unsigned        col_at;
  int unsigned        row_at;
  logic [COUNT_W-1:0] bin_counts [BINS];

  task automatic lbp_of_pixel(input logic [PIX_W-1:0] pix);
    int unsigned      w;
    int unsigned      h;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] beside;
    logic [PIX_W-1:0] ctr;
    res_word_t        r;
    w = (width_reg < MIN_SIZE) ? MIN_SIZE : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < MIN_SIZE) ? MIN_SIZE : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    if (col_at == 0 && row_at == 0) begin
      foreach (bin_counts[i]) bin_counts[i] = '0;
    end
    above  = row_above2[col_at];
    beside = row_above1[col_at];
    if (row_at >= 2 && col_at >= 2) begin
      ctr = cols_back[4];
      r.kind  = KIND_CODE;
      // bit 7 left ... bit 0 top-left
      r.code  = {cols_back[1] >= ctr, cols_back[2] >= ctr, cols_back[5] >= ctr, pix >= ctr,
                 beside >= ctr, above >= ctr, cols_back[3] >= ctr, cols_back[0] >= ctr};
      r.count = '0;
      r.eof   = (row_at >= h - 1) && (col_at >= w - 1);
      if (bin_counts[r.code] != COUNT_MAX) bin_counts[r.code]++;
      awaited.push_back(r);
    end
    cols_back[0] = cols_back[3];
    cols_back[1] = cols_back[4];
    cols_back[2] = cols_back[5];
    cols_back[3] = above;
    cols_back[4] = beside;
    cols_back[5] = pix;
    row_above2[col_at] = beside;
    row_above1[col_at] = pix;
    if (col_at >= w - 1) begin
      col_at = 0;
      row_at = (row_at >= h - 1) ? 0 : row_at + 1;
    end else begin
      col_at++;
    end
  endtask

  task automatic count_of_bin(input logic [BIN_W-1:0] idx);
    res_word_t r;
    r.kind  = KIND_COUNT;
    r.code  = '0;
    r.count = bin_counts[idx];
    r.eof   = 1'b0;
    awaited.push_back(r);
  endtask

  task automatic check_word();
    res_word_t want;
    res_word_t got;
    string     diffs;
    got = {results.kind, results.lbp_code, results.bin_count, results.end_of_frame};
    if (awaited.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: result word with nothing outstanding: kind %0d code %02h count %0d eof %0d",
                 $time, got.kind, got.code, got.count, got.eof);
      return;
    end
    want = awaited.pop_front();
    diffs = "";
    if (got.kind !== want.kind)   diffs = {diffs, " kind"};
    if (got.code !== want.code)   diffs = {diffs, " code"};
    if (got.count !== want.count) diffs = {diffs, " count"};
    if (got.eof !== want.eof)     diffs = {diffs, " eof"};
    if (want.kind == KIND_CODE) codes_checked++;
    else counts_checked++;
    if (want.eof) frame_ends++;
    if (diffs != "") begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: mismatch in%s: expected kind %0d code %02h count %0d eof %0d, got kind %0d code %02h count %0d eof %0d",
                 $time, diffs, want.kind, want.code, want.count, want.eof,
                 got.kind, got.code, got.count, got.eof);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = CFG_W'(CFG_RST);
      height_reg = CFG_W'(CFG_RST);
      foreach (row_above2[i]) row_above2[i] = '0;
      foreach (row_above1[i]) row_above1[i] = '0;
      foreach (cols_back[i]) cols_back[i] = '0;
      foreach (bin_counts[i]) bin_counts[i] = '0;
      col_at = 0;
      row_at = 0;
      awaited.delete();
      errors = 0;
      codes_checked = 0;
      counts_checked = 0;
      frame_ends = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
        col_at = 0;
        row_at = 0;
      end
      if (pixels.valid && pixels.ready) begin
        if (pixels.cmd == CMD_READ) count_of_bin(pixels.bin_index);
        else lbp_of_pixel(pixels.pixel);
      end
      if (results.valid && results.ready) check_word();
    end
    outstanding = awaited.size();
  end

endmodule

// ===== tb/tb_lbp8_code_and_histogram.sv =====
`timescale 1ns / 100ps
// tb_lbp8_code_and_histogram: stimulus and verdict for the LBP code and histogram block.
// Depends on lbph_pkg, lbph_if, the block itself and lbph_check (prediction and compare).
module tb_lbp8_code_and_histogram;
  import lbph_pkg::*;

  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 8;     // margin for a word still in flight after the last result
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, fills the queue
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int WIDE_WORDS     = 240;   // part of one widest row
  localparam int TALL_WORDS     = 300;   // first hundred rows of the tallest frame
  localparam int RANDOM_WORDS   = 1150;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;
  typedef enum logic [1:0] {STYLE_NOISE, STYLE_NARROW, STYLE_FLAT, STYLE_RAMP} pix_style_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lbph_pix_if pix_ch ();
  lbph_res_if res_ch ();

  int chk_errors;
  int chk_outstanding;
  int codes_checked;
  int counts_checked;
  int frame_ends;

  // Sender and receiver bookkeeping
  int          burst_left;
  int          pixel_words;
  int          read_words;
  int          size_settings;
  int unsigned frame_w = CFG_RST;
  int unsigned frame_h = CFG_RST;
  int          hold_requests;
  int          hold_served;
  int          hold_left;
  int          mode_left;
  rx_mode_t    rx_mode;
  int          idle_cycles;

  lbp8_code_and_histogram dut (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pix_ch),
    .results   (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lbph_check check_u (
    .clk            (clk),
    .rst            (rst),
    .pixels         (pix_ch),
    .results        (res_ch),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (chk_errors),
    .outstanding    (chk_outstanding),
    .codes_checked  (codes_checked),
    .counts_checked (counts_checked),
    .frame_ends     (frame_ends)
  );

  always #2 clk = ~clk;

  // Size as the block uses it: clamped into [3, max]
  function automatic int unsigned used_size(input logic [CFG_W-1:0] v, input int unsigned vmax);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > vmax) return vmax;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] next_pixel(input pix_style_t style,
                                                  input logic [PIX_W-1:0] base, input int idx);
    case (style)
      STYLE_NOISE:  return PIX_W'($urandom_range(0, 255));
      // narrow band: lots of equal neighbours, so the >= edge gets hit often
      STYLE_NARROW: return {base[PIX_W-1:2], 2'($urandom_range(0, 3))};
      STYLE_FLAT:   return base;
      default:      return base + PIX_W'(idx);
    endcase
  endfunction

  // Bias reads towards the bins that flat and narrow frames actually fill
  function automatic logic [BIN_W-1:0] pick_bin();
    case ($urandom_range(0, 3))
      0:       return BIN_W'(8'hFF);
      1:       return BIN_W'(8'h00);
      default: return BIN_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one word, called and returning at a falling edge. The sender runs in bursts;
  // valid stays high between words of a burst and drops only for a gap.
  task automatic send_word(input logic c, input logic [PIX_W-1:0] p, input logic [BIN_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 15) : $urandom_range(0, 2);
      if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    pix_ch.valid     <= 1'b1;
    pix_ch.cmd       <= c;
    pix_ch.pixel     <= p;
    pix_ch.bin_index <= b;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
    if (c == CMD_READ) read_words++;
    else pixel_words++;
  endtask

  // don't-care fields get random values too
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    send_word(CMD_PIXEL, p, BIN_W'($urandom_range(0, 255)));
  endtask

  task automatic send_read(input logic [BIN_W-1:0] b);
    send_word(CMD_READ, PIX_W'($urandom_range(0, 255)), b);
  endtask

  // Raster of n pixels with bin reads dropped in at random (about 1 in read_odds+1)
  task automatic send_frame(input int n, input int read_odds);
    pix_style_t       style;
    logic [PIX_W-1:0] base;
    style = pix_style_t'($urandom_range(0, 3));
    base  = PIX_W'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, read_odds) == 0) send_read(pick_bin());
      send_pixel(next_pixel(style, base, i));
    end
  endtask

  // Register writes, back to back; enable stays high across both when both are written
  task automatic write_size(input bit set_w, input bit set_h,
                            input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    if (set_w) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_WIDTH;
      cfg_data  <= w;
      frame_w = used_size(w, MAX_WIDTH);
      @(negedge clk);
    end
    if (set_h) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_HEIGHT;
      cfg_data  <= h;
      frame_h = used_size(h, MAX_HEIGHT);
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    size_settings++;
  endtask

  // Block idle: every expected word back, then SETTLE_CYCLES more for an edge pixel still
  // in flight, which gives no result and so is not visible in the outstanding count
  task automatic settle();
    pix_ch.valid <= 1'b0;
    burst_left = 0;
    while (chk_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver: a long hold-off on request, otherwise stretches of random stall density
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      res_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 96);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:  res_ch.ready <= 1'b1;
        RX_LIGHT: res_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_HALF:  res_ch.ready <= ($urandom_range(0, 1) != 0);
        default:  res_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Watchdog: ends the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results still due",
               idle_cycles, chk_outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int               phase;
    int               pick;
    int               which;
    int               frames;
    int               n;
    int               start;
    logic [CFG_W-1:0] w_raw;
    logic [CFG_W-1:0] h_raw;

    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = REG_WIDTH;
    cfg_data         = '0;
    pix_ch.valid     = 1'b0;
    pix_ch.cmd       = CMD_PIXEL;
    pix_ch.pixel     = '0;
    pix_ch.bin_index = '0;
    phase            = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- Directed part ---
    // Both sizes below the minimum, so the block runs a 3x3 frame with one interior
    // pixel. Centre 128 against a ring of 0 and 255 gives alternating code bits.
    write_size(1'b1, 1'b1, CFG_W'(0), CFG_W'(2));
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    // read mid-row: bin is empty (cleared at frame start), raster position must not move
    send_read(8'h00);
    send_pixel(8'd128);
    send_pixel(8'd0);
    send_pixel(8'd255);   // edge pixels so far: no code words
    send_pixel(8'd0);
    send_pixel(8'd255);   // only interior pixel, also last of the frame
    send_read(8'h55);
    send_read(8'hFF);
    settle();

    // Height written alone restarts the raster; counts hold until the next frame starts
    write_size(1'b0, 1'b1, '0, CFG_W'(4));
    send_read(8'h55);
    send_pixel(8'd9);     // first pixel of a frame clears every bin
    send_read(8'h55);
    repeat (11) send_pixel(8'd9);  // flat frame: every neighbour equals the centre
    send_read(8'hFF);
    settle();

    // --- Size extremes, random content ---
    // Widest row: over-range width clamps to the maximum, so part of a first row
    // must give no code words at all
    write_size(1'b1, 1'b1, CFG_W'(2047), CFG_W'(1));
    send_frame(WIDE_WORDS, 63);
    settle();
    // Tallest frame, cut short, with a long receiver hold-off while the sender keeps
    // offering; the next register write restarts the raster
    write_size(1'b1, 1'b1, CFG_W'(2), CFG_W'(2047));
    hold_requests++;
    send_frame(TALL_WORDS, 63);
    settle();

    // --- Random part: mostly whole frames at small sizes ---
    start = pixel_words + read_words;
    while (pixel_words + read_words - start < RANDOM_WORDS) begin
      phase++;
      pick = $urandom_range(0, 9);
      if (pick == 9 && phase > 1) begin
        // bin reads only, no pixels
        repeat ($urandom_range(8, 24)) send_read(BIN_W'($urandom_range(0, 255)));
      end else begin
        if (pick == 0) begin
          w_raw = CFG_W'($urandom_range(0, 2));
          h_raw = CFG_W'($urandom_range(3, 8));
        end else if (pick == 1) begin
          w_raw = CFG_W'($urandom_range(3, 12));
          h_raw = CFG_W'($urandom_range(0, 2));
        end else begin
          w_raw = CFG_W'($urandom_range(3, 16));
          h_raw = CFG_W'($urandom_range(3, 10));
        end
        // first phase writes both, so no size is left over from the extremes above
        which = (phase == 1) ? 3 : $urandom_range(0, 3);
        write_size(which != 1, which != 0, w_raw, h_raw);
        if (phase % 20 == 5) hold_requests++;
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++) begin
          n = frame_w * frame_h;
          // now and then a frame is cut short; the next register write restarts it
          if (f == frames - 1 && $urandom_range(0, 7) == 0) n = $urandom_range(1, n - 1);
          send_frame(n, 7);
          if ($urandom_range(0, 1) == 0) repeat (4) send_read(pick_bin());
        end
      end
      settle();
    end

    $display("Run covered %0d pixel words and %0d bin reads across %0d size settings",
             pixel_words, read_words, size_settings);
    $display("Checked %0d code words (%0d frame ends) and %0d bin counts, %0d mismatches",
             codes_checked, frame_ends, counts_checked, chk_errors);
    if (chk_errors == 0 && chk_outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
